// ===== design/fat_chain_allocator_defines.svh =====
// Assertion helpers shared by the allocator RTL.
// Each expects i_clk and i_rst_n in scope.
`ifndef FAT_CHAIN_ALLOCATOR_DEFINES_SVH
`define FAT_CHAIN_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define FAT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FAT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fat_pkg.sv =====
package fat_pkg;

    localparam int LEN_W = 11;  // byte_length field
    localparam int BLK_W = 5;   // block number fields
    localparam int CNT_W = 6;   // block_count field

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_BAD_START = 2'd2
    } t_status;

endpackage

// ===== design/fat_link_ram.sv =====
// Link table storage: one write port, one read port, registered read data.
// No reset: a link is only ever read for an in-use block, and allocation
// writes the link of every block it takes.
module fat_link_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/fat_need_calc.sv =====
// Blocks needed for a length: max(1, ceil(len / BLOCK_BYTES)), done as a
// multiply by a scaled reciprocal. Exact for every 11-bit length.
// Product registered on i_load; need and the space check are valid after.
module fat_need_calc #(
    parameter int NUM_BLOCKS  = 32,
    parameter int BLOCK_BYTES = 32
) (
    input  logic                               i_clk,
    input  logic                               i_load,
    input  logic [fat_pkg::LEN_W-1:0]          i_byte_length,
    input  logic [$clog2(NUM_BLOCKS+1)-1:0]    i_free_cnt,
    output logic [$clog2(NUM_BLOCKS+1)-1:0]    o_need,
    output logic                               o_no_space
);

    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int XW = $clog2((2 ** fat_pkg::LEN_W) - 1 + BLOCK_BYTES);
    localparam int K  = XW + $clog2(BLOCK_BYTES);
    localparam longint unsigned RECIP = ((64'd1 << K) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    localparam int MW = $clog2(RECIP + 1);
    localparam int PW = XW + MW;

    logic [XW-1:0] x;
    logic [PW-1:0] r_prod;
    logic [XW-1:0] quot;
    logic [XW-1:0] need;

    assign x = XW'(i_byte_length) + XW'(BLOCK_BYTES - 1);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= PW'(x) * PW'(RECIP);
        end
    end

    assign quot       = XW'(r_prod >> K);
    assign need       = (quot == '0) ? XW'(1) : quot;
    assign o_no_space = 32'(need) > 32'(i_free_cnt);
    assign o_need     = CW'(need);

endmodule

// ===== design/fat_chain_allocator.sv =====
// Block chain allocator for a file allocation table.
// Input channel (i_valid/o_ready): i_func 0 allocates a chain for
// i_byte_length bytes, 1 frees the chain that starts at i_chain_start.
// Output channel (o_valid/i_ready): one result transaction per input
// transaction with status, first and last block and block count.
// One transaction is worked on at a time; o_ready is high only when idle.
// Allocate: the request is taken and sized, then a first-fit scan of one
// block per cycle runs up to the highest block taken, then the chain is
// closed and the result handed over. Free: the walk follows the chain
// through the registered link table read, releasing each block and clearing
// its link, then hands over the result. A rejected request goes straight to
// hand-over; a no-space request is sized first.
// The in-use bitmap is in flops and is cleared at reset; no clearing pass.
// A finished result waits in the output register while the next transaction
// is taken; if the receiver stalls, the next result holds until it drains.
`include "fat_chain_allocator_defines.svh"

module fat_chain_allocator #(
    parameter int NUM_BLOCKS  = 32,
    parameter int BLOCK_BYTES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_func,
    input  logic [fat_pkg::LEN_W-1:0]   i_byte_length,
    input  logic [fat_pkg::BLK_W-1:0]   i_chain_start,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_status,
    output logic [fat_pkg::BLK_W-1:0]   o_first_block,
    output logic [fat_pkg::BLK_W-1:0]   o_last_block,
    output logic [fat_pkg::CNT_W-1:0]   o_block_count
);

    localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int LW = $clog2(NUM_BLOCKS + 1);
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam logic [LW-1:0] END_LINK = LW'(NUM_BLOCKS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_NEED = 6'b000010,
        S_SCAN = 6'b000100,
        S_TERM = 6'b001000,
        S_WALK = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state                    r_state, n_state;
    logic [NUM_BLOCKS-1:0]     r_in_use, n_in_use;
    logic [CW-1:0]             r_free_cnt, n_free_cnt;
    logic [BW-1:0]             r_idx, n_idx;
    logic [BW-1:0]             r_prev, n_prev;
    logic [BW-1:0]             r_cur, n_cur;
    logic [CW-1:0]             r_taken, n_taken;
    logic [CW-1:0]             r_need, n_need;
    logic [CW-1:0]             r_cnt, n_cnt;
    fat_pkg::t_status          r_res_status, n_res_status;
    logic [fat_pkg::BLK_W-1:0] r_res_first, n_res_first;
    logic [fat_pkg::BLK_W-1:0] r_res_last, n_res_last;
    logic [fat_pkg::CNT_W-1:0] r_res_cnt, n_res_cnt;
    logic                      r_out_valid, n_out_valid;
    fat_pkg::t_status          r_out_status;
    logic [fat_pkg::BLK_W-1:0] r_out_first, r_out_last;
    logic [fat_pkg::CNT_W-1:0] r_out_cnt;
    logic                      out_load;

    logic          wr_en, rd_en;
    logic [BW-1:0] wr_addr, rd_addr;
    logic [LW-1:0] wr_data, rd_data;

    logic          need_load, no_space;
    logic [CW-1:0] need;

    logic [BW-1:0] start_idx, nxt_idx;
    logic          start_ok, nxt_stop;

    assign o_ready   = (r_state == S_IDLE);
    assign need_load = o_ready && i_valid && !i_func;

    assign start_idx = BW'(i_chain_start);
    assign start_ok  = (32'(i_chain_start) < NUM_BLOCKS) && r_in_use[start_idx];

    // A link back to the block being freed counts as the end, so a self link ends the walk.
    assign nxt_idx  = rd_data[BW-1:0];
    assign nxt_stop = (32'(rd_data) >= NUM_BLOCKS) || (nxt_idx == r_cur)
                      || !r_in_use[nxt_idx];

    fat_need_calc #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_need (
        .i_clk         (i_clk),
        .i_load        (need_load),
        .i_byte_length (i_byte_length),
        .i_free_cnt    (r_free_cnt),
        .o_need        (need),
        .o_no_space    (no_space)
    );

    fat_link_ram #(
        .DEPTH (NUM_BLOCKS),
        .AW    (BW),
        .DW    (LW)
    ) u_links (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_in_use     = r_in_use;
        n_free_cnt   = r_free_cnt;
        n_idx        = r_idx;
        n_prev       = r_prev;
        n_cur        = r_cur;
        n_taken      = r_taken;
        n_need       = r_need;
        n_cnt        = r_cnt;
        n_res_status = r_res_status;
        n_res_first  = r_res_first;
        n_res_last   = r_res_last;
        n_res_cnt    = r_res_cnt;
        n_out_valid  = r_out_valid && !i_ready;
        out_load     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_prev;
        wr_data      = END_LINK;
        rd_en        = 1'b0;
        rd_addr      = nxt_idx;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_res_first = i_chain_start;
                    if (!i_func) begin
                        n_state = S_NEED;
                    end else if (start_ok) begin
                        rd_en   = 1'b1;
                        rd_addr = start_idx;
                        n_cur   = start_idx;
                        n_cnt   = '0;
                        n_state = S_WALK;
                    end else begin
                        n_res_status = fat_pkg::ST_BAD_START;
                        n_res_last   = '0;
                        n_res_cnt    = '0;
                        n_state      = S_DONE;
                    end
                end
            end
            S_NEED: begin
                if (no_space) begin
                    n_res_status = fat_pkg::ST_NO_SPACE;
                    n_res_first  = '0;
                    n_res_last   = '0;
                    n_res_cnt    = '0;
                    n_state      = S_DONE;
                end else begin
                    n_need  = need;
                    n_idx   = '0;
                    n_taken = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Link the previous block to this one as it is found; the
                // end marker goes on the last block in S_TERM.
                if (!r_in_use[r_idx]) begin
                    n_in_use[r_idx] = 1'b1;
                    n_free_cnt      = r_free_cnt - CW'(1);
                    if (r_taken == '0) begin
                        n_res_first = fat_pkg::BLK_W'(r_idx);
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_prev;
                        wr_data = LW'(r_idx);
                    end
                    n_prev  = r_idx;
                    n_taken = r_taken + CW'(1);
                    if (r_taken + CW'(1) == r_need) begin
                        n_state = S_TERM;
                    end
                end
                n_idx = r_idx + BW'(1);
            end
            S_TERM: begin
                wr_en        = 1'b1;
                wr_addr      = r_prev;
                wr_data      = END_LINK;
                n_res_status = fat_pkg::ST_OK;
                n_res_last   = fat_pkg::BLK_W'(r_prev);
                n_res_cnt    = fat_pkg::CNT_W'(r_taken);
                n_state      = S_DONE;
            end
            S_WALK: begin
                // rd_data is the link of r_cur. The write to r_cur and the
                // read of the next block never hit the same entry while the
                // walk goes on.
                wr_en           = 1'b1;
                wr_addr         = r_cur;
                wr_data         = END_LINK;
                n_in_use[r_cur] = 1'b0;
                n_free_cnt      = r_free_cnt + CW'(1);
                n_cnt           = r_cnt + CW'(1);
                if (nxt_stop || (r_cnt == CW'(NUM_BLOCKS - 1))) begin
                    n_res_status = fat_pkg::ST_OK;
                    n_res_last   = fat_pkg::BLK_W'(r_cur);
                    n_res_cnt    = fat_pkg::CNT_W'(r_cnt + CW'(1));
                    n_state      = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = nxt_idx;
                    n_cur   = nxt_idx;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_use    <= '0;
            r_free_cnt  <= CW'(NUM_BLOCKS);
            r_idx       <= '0;
            r_prev      <= '0;
            r_cur       <= '0;
            r_taken     <= '0;
            r_need      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_use    <= n_in_use;
            r_free_cnt  <= n_free_cnt;
            r_idx       <= n_idx;
            r_prev      <= n_prev;
            r_cur       <= n_cur;
            r_taken     <= n_taken;
            r_need      <= n_need;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_first  <= n_res_first;
        r_res_last   <= n_res_last;
        r_res_cnt    <= n_res_cnt;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_first  <= r_res_first;
            r_out_last   <= r_res_last;
            r_out_cnt    <= r_res_cnt;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_first_block = r_out_first;
    assign o_last_block  = r_out_last;
    assign o_block_count = r_out_cnt;

    `FAT_ASSERT_IMP(a_free_cnt_matches, 1'b1,
        ($countones(r_in_use) + 32'(r_free_cnt)) == NUM_BLOCKS,
        "free block count out of step with in-use bitmap")
    `FAT_ASSERT_IMP(a_walk_in_use, r_state == S_WALK, r_in_use[r_cur],
        "free walk on a block that is not in use")
    `FAT_ASSERT_IMP(a_scan_bound, r_state == S_SCAN, r_taken < r_need,
        "allocation scan took more blocks than requested")
    `FAT_ASSERT_IMP(a_no_space_zero, o_valid && (o_status == fat_pkg::ST_NO_SPACE),
        (o_block_count == '0) && (o_last_block == '0) && (o_first_block == '0),
        "no-space result carries block data")
    `FAT_ASSERT_NXT(a_done_holds, (r_state == S_DONE) && r_out_valid && !i_ready,
        (r_state == S_DONE) && r_out_valid,
        "result overwrote a stalled output")

endmodule
